// ===== rtl/rpn_pkg.sv =====
// Shared constants, opcode and status codes, and handshake structs for the
// reverse Polish stack evaluator. No dependencies.
package rpn_pkg;

  localparam int DATA_W      = 32;
  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int DIV_W       = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_END  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOEXPR   = 3'd4;

  typedef struct packed {
    logic              start;
    logic [KIND_W-1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

endpackage

// ===== rtl/rpn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the operand stack; no package dependencies.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rpn_alu.sv =====
// Shared arithmetic unit: saturating add/subtract, multiply with a fixed-point
// shift, and a one-bit-per-cycle restoring divider. Depends on rpn_pkg.
module rpn_alu (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rpn_pkg::alu_req_t        req_i,
  input  logic signed [31:0]       a_i,
  input  logic signed [31:0]       b_i,
  output rpn_pkg::alu_rsp_t        rsp_o,
  output logic signed [31:0]       result_o
);
  import rpn_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;
  localparam logic [1:0] P_FIX  = 2'd3;

  localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN64 = -64'sh0000_0000_8000_0000;

  logic [1:0]             phase_q, phase_d;
  logic                   done_q, done_d;
  logic signed [31:0]     res_q, res_d;
  logic signed [63:0]     prod_q, prod_d;
  logic [DIV_W-1:0]       quo_q, quo_d;
  logic [31:0]            rem_q, rem_d;
  logic [31:0]            dvs_q, dvs_d;
  logic                   neg_q, neg_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;

  logic signed [32:0]     sum;
  logic signed [63:0]     shifted;
  logic [31:0]            abs_a;
  logic [31:0]            abs_b;
  logic [32:0]            trial;
  logic [33:0]            diff;
  logic                   ge;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    res_d   = res_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;

    abs_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
    abs_b = b_i[31] ? 32'(-b_i) : 32'(b_i);
    if (req_i.op == KIND_SUB) begin
      sum = 33'(a_i) - 33'(b_i);
    end else begin
      sum = 33'(a_i) + 33'(b_i);
    end
    shifted = prod_q >>> FRAC_BITS;
    trial   = {rem_q, quo_q[DIV_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_q};
    ge      = ~diff[33];

    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            KIND_ADD, KIND_SUB: begin
              // Overflow of the 33-bit sum shows as differing top bits.
              if (sum[32] != sum[31]) begin
                res_d = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
              end else begin
                res_d = sum[31:0];
              end
              done_d = 1'b1;
            end
            KIND_MUL: begin
              prod_d  = 64'(a_i) * 64'(b_i);
              phase_d = P_MUL;
            end
            default: begin
              neg_d   = a_i[31] ^ b_i[31];
              quo_d   = DIV_W'(abs_a) << FRAC_BITS;
              rem_d   = '0;
              dvs_d   = abs_b;
              cnt_d   = DIV_CNT_W'(DIV_W);
              phase_d = P_DIV;
            end
          endcase
        end
      end
      P_MUL: begin
        if (shifted > MAX64) begin
          res_d = 32'sh7FFF_FFFF;
        end else if (shifted < MIN64) begin
          res_d = 32'sh8000_0000;
        end else begin
          res_d = shifted[31:0];
        end
        done_d  = 1'b1;
        phase_d = P_IDLE;
      end
      P_DIV: begin
        rem_d = ge ? diff[31:0] : trial[31:0];
        quo_d = {quo_q[DIV_W-2:0], ge};
        cnt_d = cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          phase_d = P_FIX;
        end
      end
      default: begin
        // Apply the sign to the quotient magnitude and saturate.
        if (!neg_q) begin
          res_d = (quo_q > DIV_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_q[31:0];
        end else begin
          res_d = (quo_q > DIV_W'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-quo_q[31:0]);
        end
        done_d  = 1'b1;
        phase_d = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign result_o   = res_q;

endmodule

// ===== rtl/rpn_stack_evaluator_unit.sv =====
// Top level of the reverse Polish stack evaluator: sequencer, stack control
// and output register. Depends on rpn_pkg, rpn_ram and rpn_alu.
//
// Usage: each input request carries kind_i (push, add, subtract, multiply,
// divide, end) and value_i (Q16.16 operand, used by push only). Every
// request produces exactly one output request with status_o, result_o and
// done_res_o; done_res_o marks the answer to an end request, which carries
// the popped top of the stack when no error is pending.
// Both channels use valid/ready. The unit takes one request at a time:
// in_ready_o is high only while the sequencer is idle.
// Divide is the longest operation: the restoring divider in the shared
// arithmetic unit produces one quotient bit per cycle over a quotient of
// FRAC_BITS + 32 bits (FRAC_BITS is 16 at Q16.16). The sequencer is
// idle again as the output register loads. Stack operands are read one at
// a time through the single registered read port of the stack RAM.
// The finished result sits in an output register, so a new request is
// accepted while the previous result still waits; if the receiver stalls,
// the sequencer holds its next result until the register frees up.
// Reset empties the stack, clears the sticky error and the expression flag;
// the stack RAM itself needs no clearing since only written entries are read.
module rpn_stack_evaluator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rpn_pkg::KIND_W-1:0]         kind_i,
  input  logic signed [rpn_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rpn_pkg::STATUS_W-1:0]       status_o,
  output logic signed [rpn_pkg::DATA_W-1:0]  result_o,
  output logic                               done_res_o
);
  import rpn_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GET_B = 3'd1;
  localparam logic [2:0] S_GET_A = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [STATUS_W-1:0]     err_q, err_d;
  logic                    seen_q, seen_d;
  logic [DATA_W-1:0]       b_q, b_d;

  // Pending result, formed by the sequencer before it enters the output register.
  logic [STATUS_W-1:0]     pend_status_q, pend_status_d;
  logic [DATA_W-1:0]       pend_value_q, pend_value_d;
  logic                    pend_done_q, pend_done_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [DATA_W-1:0]       out_result_q, out_result_d;
  logic                    out_done_q, out_done_d;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;

  alu_req_t                alu_req;
  alu_rsp_t                alu_rsp;
  logic signed [DATA_W-1:0] alu_result;

  logic [CNT_W-1:0]        cnt_m1;
  logic [CNT_W-1:0]        cnt_m2;
  logic                    in_accept;

  assign cnt_m1     = count_q - CNT_W'(1);
  assign cnt_m2     = count_q - CNT_W'(2);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    count_d       = count_q;
    err_d         = err_q;
    seen_d        = seen_q;
    b_d           = b_q;
    pend_status_d = pend_status_q;
    pend_value_d  = pend_value_q;
    pend_done_d   = pend_done_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_result_d  = out_result_q;
    out_done_d    = out_done_q;

    ram_we        = 1'b0;
    ram_waddr     = count_q[ADDR_W-1:0];
    ram_wdata     = value_i;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[ADDR_W-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = kind_q;

    case (state_q)
      S_IDLE: begin
        // The top entry is read speculatively; it is used only by operators
        // and by an end request on a non-empty stack.
        ram_re = 1'b1;
        if (in_accept) begin
          kind_d        = kind_i;
          pend_value_d  = '0;
          pend_done_d   = 1'b0;
          state_d       = S_RESP;
          if (kind_i == KIND_END) begin
            pend_done_d = 1'b1;
            if (err_q != ST_OK) begin
              pend_status_d = err_q;
            end else if (!seen_q) begin
              pend_status_d = ST_NOEXPR;
            end else if (count_q == '0) begin
              pend_status_d = ST_EMPTY;
            end else begin
              state_d = S_GET_B;
            end
            if (state_d == S_RESP) begin
              count_d = '0;
              err_d   = ST_OK;
              seen_d  = 1'b0;
            end
          end else if (kind_i <= KIND_DIV) begin
            seen_d        = 1'b1;
            pend_status_d = err_q;
            if (err_q != ST_OK) begin
              // A pending error freezes the stack until the end request.
            end else if (kind_i == KIND_PUSH) begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                err_d         = ST_OVERFLOW;
                pend_status_d = ST_OVERFLOW;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end else if (count_q == '0) begin
              err_d         = ST_EMPTY;
              pend_status_d = ST_EMPTY;
            end else begin
              state_d = S_GET_B;
            end
          end else begin
            // Undefined kinds leave the stack, the error and the expression flag alone.
            pend_status_d = err_q;
          end
        end
      end
      S_GET_B: begin
        // ram_rdata holds the top entry (the right operand).
        state_d = S_RESP;
        if (kind_q == KIND_END) begin
          pend_status_d = ST_OK;
          pend_value_d  = ram_rdata;
          count_d       = '0;
          err_d         = ST_OK;
          seen_d        = 1'b0;
        end else if ((kind_q == KIND_DIV) && (ram_rdata == '0)) begin
          // A zero divisor is reported even when the left operand is missing.
          err_d         = ST_DIVZERO;
          pend_status_d = ST_DIVZERO;
        end else if (count_q < CNT_W'(2)) begin
          err_d         = ST_EMPTY;
          pend_status_d = ST_EMPTY;
        end else begin
          b_d       = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = cnt_m2[ADDR_W-1:0];
          state_d   = S_GET_A;
        end
      end
      S_GET_A: begin
        alu_req.start = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          ram_we        = 1'b1;
          ram_waddr     = cnt_m2[ADDR_W-1:0];
          ram_wdata     = alu_result;
          count_d       = cnt_m1;
          pend_status_d = ST_OK;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_result_d = pend_value_q;
          out_done_d   = pend_done_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    b_q           <= b_d;
    pend_status_q <= pend_status_d;
    pend_value_q  <= pend_value_d;
    pend_done_q   <= pend_done_d;
    out_status_q  <= out_status_d;
    out_result_q  <= out_result_d;
    out_done_q    <= out_done_d;
  end

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (ram_rdata),
    .b_i      (b_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign result_o    = out_result_q;
  assign done_res_o  = out_done_q;

endmodule
